[rtl/core/u16u8_pkg.sv]
// Shared types, constants and UTF-8 byte helpers for the UTF-16LE to UTF-8 transcoder.
// Depends on nothing; imported by the front, queue, back and top-level modules.
package u16u8_pkg;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;
    localparam logic [20:0] PAIR_BASE  = 21'h10000;
    localparam logic [20:0] ONE_MAX    = 21'h7F;
    localparam logic [20:0] TWO_MAX    = 21'h7FF;
    localparam logic [20:0] THREE_MAX  = 21'hFFFF;
    localparam logic [7:0]  LEAD2      = 8'hC0;
    localparam logic [7:0]  LEAD3      = 8'hE0;
    localparam logic [7:0]  LEAD4      = 8'hF0;
    localparam logic [7:0]  CONT       = 8'h80;
    localparam logic [7:0]  TERM_BYTE  = 8'h00;
    localparam logic [2:0]  SURR_LEN   = 3'd3;

    // One classified input transaction: an optional flushed high surrogate,
    // an optional code point and an optional terminator, in that order.
    typedef struct packed {
        logic        has_flush;
        logic [9:0]  flush_bits;
        logic        has_cp;
        logic [20:0] cp;
        logic        has_term;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] len;
        if (cp <= ONE_MAX)
            len = 3'd1;
        else if (cp <= TWO_MAX)
            len = 3'd2;
        else if (cp <= THREE_MAX)
            len = 3'd3;
        else
            len = 3'd4;
        return len;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                             input logic [1:0] idx);
        logic [7:0] b;
        b = TERM_BYTE;
        case (len)
            3'd1:
            begin
                b = cp[7:0];
            end
            3'd2:
            begin
                case (idx)
                    2'd0:    b = LEAD2 | {3'b000, cp[10:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
            3'd3:
            begin
                case (idx)
                    2'd0:    b = LEAD3 | {4'b0000, cp[15:12]};
                    2'd1:    b = CONT | {2'b00, cp[11:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
            default:
            begin
                case (idx)
                    2'd0:    b = LEAD4 | {5'b00000, cp[20:18]};
                    2'd1:    b = CONT | {2'b00, cp[17:12]};
                    2'd2:    b = CONT | {2'b00, cp[11:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

[rtl/core/utf16le_to_utf8_transcoder.sv]
// Top level of the UTF-16LE to UTF-8 transcoder: front end, job queue, byte sequencer.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.
//
//  channel | handshake            | payload                        | per transaction
//  --------+----------------------+--------------------------------+---------------------
//  input   | in_valid / in_ready  | code_unit[15:0], last_unit     | one UTF-16 code unit
//  output  | out_valid / out_ready| out_byte[7:0], run_last,       | one UTF-8 byte
//          |                      | text_end                       |
//
// Rates: the front end takes one code unit per cycle while the job queue has room;
// the sequencer issues one byte per cycle while the output is not stalled, and each unit
// causes 0 to 7 bytes, so the input is bounded by the output byte rate.
// Order: a job is first stored in the queue; its bytes are then registered at the output.
// Reset: rst_n clears surrogate/text state, queue pointers and the output valid flag.
// Stalls: out_ready low holds the output register; the queue absorbs up to QUEUE_DEPTH
// jobs before in_ready drops.
module utf16le_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] code_unit,
    input  logic        last_unit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        text_end
);
    import u16u8_pkg::*;

    q_status_t q_status;
    job_t      push_job;
    job_t      head_job;
    logic      push;
    logic      pop;

    // classify each code unit and hold a pending high surrogate
    u16u8_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .code_unit(code_unit),
        .last_unit(last_unit),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    // decouple classification from byte issue
    u16u8_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .head_job(head_job),
        .status  (q_status)
    );

    // expand each job into its byte run
    u16u8_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .q_status (q_status),
        .pop      (pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_byte (out_byte),
        .run_last (run_last),
        .text_end (text_end)
    );

endmodule

[rtl/core/u16u8_front.sv]
// Front end: accepts code units, tracks surrogate and text state, builds jobs.
// Depends on u16u8_pkg; feeds u16u8_queue.
module u16u8_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [15:0]           code_unit,
    input  logic                  last_unit,
    input  u16u8_pkg::q_status_t  q_status,
    output logic                  push,
    output u16u8_pkg::job_t       push_job
);
    import u16u8_pkg::*;

    logic [9:0] held_bits_reg, held_bits_next;
    logic       held_valid_reg, held_valid_next;
    logic       text_done_reg, text_done_next;
    logic       accept;
    logic       is_high;
    logic       is_low;
    job_t       job;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign is_high  = code_unit inside {[HIGH_FIRST:HIGH_LAST]};
    assign is_low   = code_unit inside {[LOW_FIRST:LOW_LAST]};

    always_comb
    begin
        job             = '0;
        held_bits_next  = held_bits_reg;
        held_valid_next = held_valid_reg;
        text_done_next  = text_done_reg;
        if (!text_done_reg)
        begin
            if (held_valid_reg && is_low)
            begin
                job.has_cp      = 1'b1;
                job.cp          = PAIR_BASE + {1'b0, held_bits_reg, code_unit[9:0]};
                held_valid_next = 1'b0;
                held_bits_next  = '0;
            end
            else
            begin
                if (held_valid_reg)
                begin
                    job.has_flush   = 1'b1;
                    job.flush_bits  = held_bits_reg;
                    held_valid_next = 1'b0;
                    held_bits_next  = '0;
                end
                if (code_unit == 16'h0000)
                begin
                    job.has_term   = 1'b1;
                    text_done_next = 1'b1;
                end
                else if (is_high && !last_unit)
                begin
                    held_bits_next  = code_unit[9:0];
                    held_valid_next = 1'b1;
                end
                else
                begin
                    job.has_cp = 1'b1;
                    job.cp     = {5'd0, code_unit};
                end
            end
            if (last_unit && !text_done_next)
            begin
                job.has_term   = 1'b1;
                text_done_next = 1'b1;
            end
        end
        // drop all message state after the last unit
        if (last_unit)
        begin
            held_bits_next  = '0;
            held_valid_next = 1'b0;
            text_done_next  = 1'b0;
        end
    end

    assign push     = accept && (job.has_flush || job.has_cp || job.has_term);
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bits_reg  <= '0;
            held_valid_reg <= 1'b0;
            text_done_reg  <= 1'b0;
        end
        else if (accept)
        begin
            held_bits_reg  <= held_bits_next;
            held_valid_reg <= held_valid_next;
            text_done_reg  <= text_done_next;
        end
    end

endmodule

[rtl/core/u16u8_queue.sv]
// Small job queue between the front end and the byte sequencer.
// Depends on u16u8_pkg for the job and status types.
module u16u8_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  u16u8_pkg::job_t       push_job,
    input  logic                  pop,
    output u16u8_pkg::job_t       head_job,
    output u16u8_pkg::q_status_t  status
);
    import u16u8_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

[rtl/core/u16u8_back.sv]
// Back end: walks the job at the queue head and issues one UTF-8 byte per cycle while not stalled.
// Depends on u16u8_pkg for the job type and byte helpers.
module u16u8_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  u16u8_pkg::job_t       head_job,
    input  u16u8_pkg::q_status_t  q_status,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  run_last,
    output logic                  text_end
);
    import u16u8_pkg::*;

    logic [1:0]  idx_reg, idx_next;
    logic        flush_done_reg, flush_done_next;
    logic        cp_done_reg, cp_done_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        run_last_reg;
    logic        text_end_reg;
    logic        in_flush;
    logic        in_cp;
    logic        in_term;
    logic [20:0] seg_value;
    logic [2:0]  seg_len;
    logic        seg_final;
    logic        job_final;
    logic        issue;
    logic [7:0]  cur_byte;

    assign in_flush  = head_job.has_flush && !flush_done_reg;
    assign in_cp     = !in_flush && head_job.has_cp && !cp_done_reg;
    assign in_term   = !in_flush && !in_cp;
    assign seg_value = in_flush ? (21'(HIGH_FIRST) | {11'd0, head_job.flush_bits}) : head_job.cp;
    assign seg_len   = in_flush ? SURR_LEN : (in_cp ? utf8_len(head_job.cp) : 3'd1);
    assign seg_final = ({1'b0, idx_reg} == (seg_len - 3'd1));
    assign job_final = in_term
                    || (in_cp && seg_final && !head_job.has_term)
                    || (in_flush && seg_final && !head_job.has_cp && !head_job.has_term);
    assign cur_byte  = in_term ? TERM_BYTE : utf8_byte(seg_value, seg_len, idx_reg);
    assign issue     = !q_status.empty && (!out_valid_reg || out_ready);
    assign pop       = issue && job_final;

    always_comb
    begin
        idx_next        = idx_reg;
        flush_done_next = flush_done_reg;
        cp_done_next    = cp_done_reg;
        out_valid_next  = out_valid_reg;
        if (issue)
        begin
            out_valid_next = 1'b1;
            if (job_final)
            begin
                idx_next        = '0;
                flush_done_next = 1'b0;
                cp_done_next    = 1'b0;
            end
            else if (seg_final)
            begin
                idx_next = '0;
                if (in_flush)
                    flush_done_next = 1'b1;
                else
                    cp_done_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            flush_done_reg <= 1'b0;
            cp_done_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            idx_reg        <= idx_next;
            flush_done_reg <= flush_done_next;
            cp_done_reg    <= cp_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            out_byte_reg <= cur_byte;
            run_last_reg <= job_final;
            text_end_reg <= in_term;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign text_end  = text_end_reg;

endmodule

[rtl/core/u16u8_checker.sv]
// Port-level checks for the UTF-16LE to UTF-8 transcoder, bound to its top level.
// Depends only on the top-level ports.
module u16u8_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [15:0] code_unit,
    input logic        last_unit,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic        run_last,
    input logic        text_end
);

    // hold a stalled output transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last)
                                    && $stable(text_end))
        else $error("output transaction changed while stalled");

    // a terminator is a zero byte and closes its run
    a_term_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_end |-> out_byte == 8'h00 && run_last)
        else $error("terminator malformed");

    // a zero byte only ever comes as the terminator
    a_zero_is_term: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_byte == 8'h00 |-> text_end)
        else $error("zero byte outside terminator");

    // a lead byte of a multi-byte sequence never ends a run
    a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_byte[7:6] == 2'b11 |-> !run_last)
        else $error("run ended on a lead byte");

    // nothing offered while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind utf16le_to_utf8_transcoder u16u8_checker u_checker (.*);
